// ----- design/mfpc_pkg.sv -----
// Shared types and constants for the minimum falling path cost block.
package mfpc_pkg;

  // Configuration register layout
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

  // Cost datapath
  localparam int COST_W = 24;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_COLS  = 256;
  localparam int DEF_MAX_ROWS  = 256;
  localparam int DEF_FARE_BITS = 16;

  // Queue between front and back, result buffer on the output side
  localparam int QUEUE_DEPTH = 2;
  localparam int RES_DEPTH   = 4;
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);

  // Position flags worked out by the front for every fare
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic first_col;
    logic last_col;
  } item_flags_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic [RES_CNT_W-1:0] res_count;
    logic                 s1_last;
  } back_stat_t;

endpackage

// ----- design/min_falling_path_cost_core.sv -----
// Top level of the streaming minimum falling path cost block.
//
// Usage:
//   Fares enter on the in_ channel in row-major order, rows from the top down,
//   one fare per transfer (in_valid high and in_stall low at a rising edge).
//   After the last fare of the last row the block delivers one min_cost on the
//   out_ channel: the cheapest path cost over the whole grid, where each step
//   moves to the same column or a neighboring one in the next row. Sums
//   saturate at 24 bits all ones.
//   grid_rows (index 0) and grid_cols (index 1) are written through cfg_we /
//   cfg_index / cfg_wdata while the block is idle; 0 acts as 1, values above
//   MAX_ROWS / MAX_COLS clamp. Any write restarts the grid.
// Throughput: one fare per cycle while in_stall is low, with the cost update in the
//   back end working against its two-read, one-write line buffer.
// Result path: the grid's last fare passes through the queue and the compute stage,
//   and its min_cost is then registered in the result buffer.
// Reset: synchronous, active low; sizes return to 1x1, position clears and the
//   running minimum returns to all ones. The line buffer needs no clearing: row zero fills it.
// Stall: up to four results wait in an output buffer while out_stall is high;
//   fares keep flowing until that buffer would overflow, then in_stall rises.
module min_falling_path_cost_core #(
  parameter int MAX_COLS  = mfpc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS  = mfpc_pkg::DEF_MAX_ROWS,
  parameter int FARE_BITS = mfpc_pkg::DEF_FARE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mfpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfpc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [FARE_BITS-1:0]           in_fare,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mfpc_pkg::COST_W-1:0]    out_min_cost
);

  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FLAG_W = $bits(mfpc_pkg::item_flags_t);
  localparam int QW     = FARE_BITS + CW + FLAG_W;

  logic                  q_full, q_push, q_pop, q_valid, restart;
  logic [FARE_BITS-1:0]  f_fare, b_fare;
  logic [CW-1:0]         f_col, b_col;
  mfpc_pkg::item_flags_t f_flags, b_flags;
  logic [QW-1:0]         q_head;
  mfpc_pkg::back_stat_t  stat;

  // Front: classifies each fare by grid position
  mfpc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .FARE_BITS(FARE_BITS),
    .CW       (CW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_fare  (in_fare),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_fare   (f_fare),
    .q_col    (f_col),
    .q_flags  (f_flags),
    .restart  (restart)
  );

  // Decoupling queue
  mfpc_queue #(
    .DATA_W(QW),
    .DEPTH (mfpc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({f_fare, f_col, f_flags}),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  assign b_fare  = q_head[QW-1 -: FARE_BITS];
  assign b_col   = q_head[FLAG_W +: CW];
  assign b_flags = q_head[FLAG_W-1:0];

  // Back: line buffer update and result delivery
  mfpc_back #(
    .MAX_COLS (MAX_COLS),
    .FARE_BITS(FARE_BITS),
    .CW       (CW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .q_valid     (q_valid),
    .q_fare      (b_fare),
    .q_col       (b_col),
    .q_flags     (b_flags),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_min_cost(out_min_cost),
    .stat        (stat)
  );

`ifndef SYNTHESIS
  // Back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Result buffer never overfills, counting the grid end in flight
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_count + stat.s1_last <= mfpc_pkg::RES_DEPTH)
    else $error("result buffer overflow");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_cost))
    else $error("stalled result changed");
`endif

endmodule

// ----- design/mfpc_front.sv -----
// Front end: configuration registers, grid position counters and item tagging.
module mfpc_front #(
  parameter int MAX_COLS  = mfpc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS  = mfpc_pkg::DEF_MAX_ROWS,
  parameter int FARE_BITS = mfpc_pkg::DEF_FARE_BITS,
  parameter int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mfpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfpc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [FARE_BITS-1:0]           in_fare,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [FARE_BITS-1:0]           q_fare,
  output logic [CW-1:0]                  q_col,
  output mfpc_pkg::item_flags_t          q_flags,
  output logic                           restart
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [mfpc_pkg::CFG_W-1:0] rows_r, rows_nxt;
  logic [mfpc_pkg::CFG_W-1:0] cols_r, cols_nxt;
  logic [RW-1:0]              row_r, row_nxt;
  logic [CW-1:0]              col_r, col_nxt;
  logic [RW-1:0]              rows_m1;
  logic [CW-1:0]              cols_m1;
  logic                       accept;

  // Effective size minus one: zero acts as one, oversize clamps
  always_comb begin
    if (rows_r == '0) begin
      rows_m1 = '0;
    end else if (32'(rows_r) > MAX_ROWS) begin
      rows_m1 = RW'(MAX_ROWS - 1);
    end else begin
      rows_m1 = RW'(32'(rows_r) - 32'd1);
    end
    if (cols_r == '0) begin
      cols_m1 = '0;
    end else if (32'(cols_r) > MAX_COLS) begin
      cols_m1 = CW'(MAX_COLS - 1);
    end else begin
      cols_m1 = CW'(32'(cols_r) - 32'd1);
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign restart  = cfg_we;

  assign q_push            = accept;
  assign q_fare            = in_fare;
  assign q_col             = col_r;
  assign q_flags.first_row = (row_r == '0);
  assign q_flags.last_row  = (row_r == rows_m1);
  assign q_flags.first_col = (col_r == '0);
  assign q_flags.last_col  = (col_r == cols_m1);

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (cfg_we) begin
      case (cfg_index)
        mfpc_pkg::REG_GRID_ROWS: rows_nxt = cfg_wdata;
        mfpc_pkg::REG_GRID_COLS: cols_nxt = cfg_wdata;
        default: ;
      endcase
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (q_flags.last_col) begin
        col_nxt = '0;
        row_nxt = q_flags.last_row ? '0 : RW'(row_r + 1'b1);
      end else begin
        col_nxt = CW'(col_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= mfpc_pkg::CFG_W'(1);
      cols_r <= mfpc_pkg::CFG_W'(1);
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

// ----- design/mfpc_queue.sv -----
// Small FIFO that decouples the front end from the back end.
module mfpc_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = mfpc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]     count_r, count_nxt;

  assign full  = (count_r == NW'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = NW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = NW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- design/mfpc_back.sv -----
// Back end: line buffer, cost update, running minimum and result buffer.
module mfpc_back #(
  parameter int MAX_COLS  = mfpc_pkg::DEF_MAX_COLS,
  parameter int FARE_BITS = mfpc_pkg::DEF_FARE_BITS,
  parameter int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  input  logic                                q_valid,
  input  logic [FARE_BITS-1:0]                q_fare,
  input  logic [CW-1:0]                       q_col,
  input  mfpc_pkg::item_flags_t               q_flags,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mfpc_pkg::COST_W-1:0]         out_min_cost,
  output mfpc_pkg::back_stat_t                stat
);

  localparam int COST_W = mfpc_pkg::COST_W;
  localparam int SUM_W  = ((FARE_BITS > COST_W) ? FARE_BITS : COST_W) + 1;
  localparam int RCW    = mfpc_pkg::RES_CNT_W;
  localparam int RPW    = mfpc_pkg::RES_PTR_W;

  // Line buffer of previous-row costs
  logic [COST_W-1:0] line_mem [MAX_COLS];
  logic [COST_W-1:0] rd_here_r, rd_right_r;
  logic [CW-1:0]     ra_here, ra_right;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  logic [COST_W-1:0] wr_data;

  // Write-through forwarding for reads that hit the entry being written
  logic              fwd_here_r, fwd_right_r;
  logic [COST_W-1:0] fwd_data_r;

  // Compute stage
  logic                  s1_valid_r;
  logic [FARE_BITS-1:0]  s1_fare_r;
  logic [CW-1:0]         s1_col_r;
  mfpc_pkg::item_flags_t s1_flags_r;

  logic [COST_W-1:0] left_old_r;
  logic [COST_W-1:0] run_min_r, run_min_nxt;
  logic [COST_W-1:0] here, right, best, cost, cand;
  logic [SUM_W-1:0]  sum;

  // Result buffer
  logic [COST_W-1:0] res_r [mfpc_pkg::RES_DEPTH];
  logic [RPW-1:0]    res_wr_r, res_rd_r;
  logic [RCW-1:0]    res_cnt_r, res_cnt_nxt;
  logic              res_push, res_pop, s1_last, is_last, room;

  // A grid-ending fare goes on only if its result has a slot waiting
  assign s1_last = s1_valid_r && s1_flags_r.last_row && s1_flags_r.last_col;
  assign is_last = q_flags.last_row && q_flags.last_col;
  assign room    = ({1'b0, res_cnt_r} + (RCW+1)'(s1_last)) < (RCW+1)'(mfpc_pkg::RES_DEPTH);
  assign q_pop   = q_valid && (!is_last || room);

  assign ra_here  = q_col;
  assign ra_right = q_flags.last_col ? q_col : CW'(q_col + 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    rd_here_r   <= line_mem[ra_here];
    rd_right_r  <= line_mem[ra_right];
    fwd_here_r  <= wr_en && (wr_addr == ra_here);
    fwd_right_r <= wr_en && (wr_addr == ra_right);
    fwd_data_r  <= wr_data;
    s1_fare_r   <= q_fare;
    s1_col_r    <= q_col;
    s1_flags_r  <= q_flags;
  end

  assign here  = fwd_here_r  ? fwd_data_r : rd_here_r;
  assign right = fwd_right_r ? fwd_data_r : rd_right_r;

  always_comb begin
    best = here;
    if (!s1_flags_r.first_col && left_old_r < best) begin
      best = left_old_r;
    end
    if (!s1_flags_r.last_col && right < best) begin
      best = right;
    end
    if (s1_flags_r.first_row) begin
      best = '0;
    end
  end

  // Saturating add
  assign sum  = SUM_W'(s1_fare_r) + SUM_W'(best);
  assign cost = (sum > SUM_W'(mfpc_pkg::COST_MAX)) ? mfpc_pkg::COST_MAX : sum[COST_W-1:0];
  assign cand = (cost < run_min_r) ? cost : run_min_r;

  assign wr_en   = s1_valid_r;
  assign wr_addr = s1_col_r;
  assign wr_data = cost;

  always_comb begin
    run_min_nxt = run_min_r;
    if (restart) begin
      run_min_nxt = mfpc_pkg::COST_MAX;
    end else if (s1_valid_r && s1_flags_r.last_row) begin
      run_min_nxt = s1_flags_r.last_col ? mfpc_pkg::COST_MAX : cand;
    end
  end

  assign res_push = s1_last;
  assign res_pop  = out_valid && !out_stall;

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (res_push && !res_pop) begin
      res_cnt_nxt = RCW'(res_cnt_r + 1'b1);
    end else if (res_pop && !res_push) begin
      res_cnt_nxt = RCW'(res_cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      left_old_r <= here;
    end
    if (res_push) begin
      res_r[res_wr_r] <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      run_min_r  <= mfpc_pkg::COST_MAX;
      res_wr_r   <= '0;
      res_rd_r   <= '0;
      res_cnt_r  <= '0;
    end else begin
      s1_valid_r <= q_pop;
      run_min_r  <= run_min_nxt;
      res_cnt_r  <= res_cnt_nxt;
      if (res_push) begin
        res_wr_r <= RPW'(res_wr_r + 1'b1);
      end
      if (res_pop) begin
        res_rd_r <= RPW'(res_rd_r + 1'b1);
      end
    end
  end

  assign out_valid    = (res_cnt_r != '0);
  assign out_min_cost = res_r[res_rd_r];

  assign stat.res_count = res_cnt_r;
  assign stat.s1_last   = s1_last;

endmodule

// ----- sim/tb_min_falling_path_cost_core.sv -----
// Testbench for min_falling_path_cost_core: directed grids, then random ones,
// checked against a built-in cost predictor or, for some directed fares, typed-in costs.
module tb_min_falling_path_cost_core;

  localparam int MAX_COLS   = mfpc_pkg::DEF_MAX_COLS;
  localparam int MAX_ROWS   = mfpc_pkg::DEF_MAX_ROWS;
  localparam int FARE_W     = mfpc_pkg::DEF_FARE_BITS;
  localparam int RAND_FARES = 1650;
  localparam int QUIET_MAX  = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT = 4;     // pause for a partial grid still in flight

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [mfpc_pkg::CFG_IDX_W-1:0]  cfg_index = mfpc_pkg::REG_GRID_ROWS;
  logic [mfpc_pkg::CFG_W-1:0]      cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [FARE_W-1:0]               in_fare = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [mfpc_pkg::COST_W-1:0]     out_min_cost;

  min_falling_path_cost_core #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .FARE_BITS(FARE_W)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_fare     (in_fare),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_min_cost(out_min_cost)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cost predictor: its own copy of the sizes, the line buffer and the position
  // ---------------------------------------------------------------------------
  logic [mfpc_pkg::CFG_W-1:0]  p_rows, p_cols;
  logic [mfpc_pkg::COST_W-1:0] p_line [MAX_COLS];
  int unsigned                 p_row, p_col;
  logic [mfpc_pkg::COST_W-1:0] p_left;  // previous-row cost at j-1, before overwrite
  logic [mfpc_pkg::COST_W-1:0] p_min;   // running minimum over the last row

  logic [mfpc_pkg::COST_W-1:0] min_cost_q [$];  // expected costs, oldest first

  int  errors       = 0;
  int  fares_sent   = 0;
  bit  no_idle      = 1'b0;

  // 0 acts as 1, anything above the maximum clamps
  function automatic int unsigned eff_size(input logic [mfpc_pkg::CFG_W-1:0] v,
                                           input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic logic [mfpc_pkg::COST_W-1:0] sat_add(
      input logic [mfpc_pkg::COST_W-1:0] a, input logic [FARE_W-1:0] b);
    logic [mfpc_pkg::COST_W:0] s;
    s = {1'b0, a} + (mfpc_pkg::COST_W+1)'(b);
    return (s > mfpc_pkg::COST_MAX) ? mfpc_pkg::COST_MAX : s[mfpc_pkg::COST_W-1:0];
  endfunction

  task automatic restart_grid();
    p_row  = 0;
    p_col  = 0;
    p_left = '0;
    p_min  = mfpc_pkg::COST_MAX;
  endtask

  // Fold one accepted fare into the predicted state; queue a cost at grid end.
  // A typed-in value, where given, stands in for the predicted one.
  task automatic fold_fare(input logic [FARE_W-1:0] f, input logic typed,
                           input logic [mfpc_pkg::COST_W-1:0] want);
    int unsigned                 nr, nc, j;
    logic [mfpc_pkg::COST_W-1:0] cost, here, best;
    nr = eff_size(p_rows, MAX_ROWS);
    nc = eff_size(p_cols, MAX_COLS);
    if (p_row >= nr || p_col >= nc) restart_grid();
    j = p_col;
    if (p_row == 0) begin
      cost = sat_add('0, f);
    end else begin
      here = p_line[j];
      best = here;
      if (j > 0 && p_left < best) best = p_left;
      if (j + 1 < nc && p_line[j+1] < best) best = p_line[j+1];
      p_left = here;
      cost   = sat_add(best, f);
    end
    p_line[j] = cost;
    if (p_row + 1 == nr && cost < p_min) p_min = cost;
    if (j + 1 < nc) begin
      p_col = j + 1;
    end else begin
      p_col  = 0;
      p_left = '0;
      if (p_row + 1 < nr) begin
        p_row++;
      end else begin
        min_cost_q.push_back(typed ? want : p_min);
        restart_grid();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. Everything is driven with NBAs right after a rising edge, and
  // handshakes are sampled at that point, i.e. with their pre-edge values.
  // ---------------------------------------------------------------------------

  // One fare transfer, with random idle cycles ahead of it unless no_idle is set
  task automatic send_fare(input logic [FARE_W-1:0] f, input logic typed,
                           input logic [mfpc_pkg::COST_W-1:0] want);
    cfg_we <= 1'b0;
    while (!no_idle && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_fare  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_fare(f, typed, want);
    fares_sent++;
    no_idle = (fares_sent >= 700 && fares_sent < 1000);
  endtask

  // Quiesce: no fare in flight and every queued cost delivered, then a pause
  // for a partial grid that may still be working its way through.
  task automatic wait_drain();
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    while (min_cost_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Register write; cfg_we is left high and lowered by the next driver step
  task automatic cfg_write(input logic [mfpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mfpc_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == mfpc_pkg::REG_GRID_ROWS) p_rows = val;
    else if (idx == mfpc_pkg::REG_GRID_COLS) p_cols = val;
    restart_grid();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and out_stall generation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what,
                                 input logic [mfpc_pkg::COST_W-1:0] got,
                                 input logic [mfpc_pkg::COST_W-1:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [mfpc_pkg::COST_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (min_cost_q.size() == 0) begin
        report_mismatch("unexpected min_cost", out_min_cost, '0);
      end else begin
        want = min_cost_q.pop_front();
        if (out_min_cost !== want) report_mismatch("min_cost", out_min_cost, want);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 29);
  end

  // Watchdog on cycles without any transfer or register write
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_CFG, ROW_FARE} row_kind_t;

  typedef enum int {FARE_ANY, FARE_LOW, FARE_MAX, FARE_EDGE} fare_mode_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [mfpc_pkg::CFG_IDX_W-1:0] idx;
    logic [mfpc_pkg::CFG_W-1:0]     val;
    logic [FARE_W-1:0]              fare;
    logic                           typed;   // want holds the cost this fare completes
    logic [mfpc_pkg::COST_W-1:0]    want;
  } dir_row_t;

  function automatic dir_row_t fare_row(input logic [FARE_W-1:0] f, input logic typed,
                                        input logic [mfpc_pkg::COST_W-1:0] want);
    return '{kind: ROW_FARE, idx: mfpc_pkg::REG_GRID_ROWS, val: '0, fare: f,
             typed: typed, want: want};
  endfunction

  function automatic dir_row_t cfg_row(input logic [mfpc_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [mfpc_pkg::CFG_W-1:0] val);
    return '{kind: ROW_CFG, idx: idx, val: val, fare: '0, typed: 1'b0, want: '0};
  endfunction

  localparam int DIR_N = 29;
  dir_row_t dir_tab [DIR_N];

  function automatic logic [FARE_W-1:0] pick_fare(input fare_mode_t mode);
    case (mode)
      FARE_ANY: return FARE_W'($urandom_range(65535));
      FARE_LOW: return FARE_W'($urandom_range(15));
      FARE_MAX: return '1;
      default: begin
        case ($urandom_range(2))
          0:       return '0;
          1:       return '1;
          default: return FARE_W'($urandom_range(65535));
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned                nr, nc, ngrids, cut, n;
    fare_mode_t                 mode;
    int                         r;
    logic [mfpc_pkg::CFG_W-1:0] rv, cv;

    p_rows = mfpc_pkg::CFG_W'(1);
    p_cols = mfpc_pkg::CFG_W'(1);
    restart_grid();

    dir_tab = '{
      // 1x1 after reset: each fare is its own grid; extremes and bit patterns
      fare_row(16'h0000, 1'b1, 24'd0),
      fare_row(16'hFFFF, 1'b1, 24'd65535),
      fare_row(16'h5555, 1'b1, 24'h005555),
      fare_row(16'hAAAA, 1'b1, 24'h00AAAA),
      // zero sizes act as one
      cfg_row(mfpc_pkg::REG_GRID_ROWS, 9'd0),
      cfg_row(mfpc_pkg::REG_GRID_COLS, 9'd0),
      fare_row(16'd7, 1'b1, 24'd7),
      // 2x3 grid, neighbors on both sides and at the edges
      cfg_row(mfpc_pkg::REG_GRID_ROWS, 9'd2),
      cfg_row(mfpc_pkg::REG_GRID_COLS, 9'd3),
      fare_row(16'd5, 1'b0, '0),
      fare_row(16'd1, 1'b0, '0),
      fare_row(16'd9, 1'b0, '0),
      fare_row(16'd2, 1'b0, '0),
      fare_row(16'd8, 1'b0, '0),
      fare_row(16'd3, 1'b0, '0),
      // single column of max fares
      cfg_row(mfpc_pkg::REG_GRID_ROWS, 9'd3),
      cfg_row(mfpc_pkg::REG_GRID_COLS, 9'd1),
      fare_row(16'hFFFF, 1'b0, '0),
      fare_row(16'hFFFF, 1'b0, '0),
      fare_row(16'hFFFF, 1'b1, 24'd196605),
      // half a grid, then a register write restarts it
      cfg_row(mfpc_pkg::REG_GRID_ROWS, 9'd2),
      cfg_row(mfpc_pkg::REG_GRID_COLS, 9'd2),
      fare_row(16'd4, 1'b0, '0),
      fare_row(16'd6, 1'b0, '0),
      cfg_row(mfpc_pkg::REG_GRID_COLS, 9'd2),
      fare_row(16'd1, 1'b0, '0),
      fare_row(16'd2, 1'b0, '0),
      fare_row(16'd3, 1'b0, '0),
      fare_row(16'd4, 1'b0, '0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_drain();
        cfg_write(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_fare(dir_tab[i].fare, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases: new sizes, a few whole grids, now and then a cut-off grid
    while (fares_sent < DIR_N + RAND_FARES) begin
      r = $urandom_range(99);
      if (r < 6) begin
        // tall: one dimension at or past the maximum, the other tiny
        case ($urandom_range(2))
          0:       rv = 9'd256;
          1:       rv = 9'd300;
          default: rv = 9'd511;
        endcase
        cv = mfpc_pkg::CFG_W'($urandom_range(2));
        ngrids = 1;
      end else if (r < 12) begin
        case ($urandom_range(2))
          0:       cv = 9'd256;
          1:       cv = 9'd257;
          default: cv = 9'd511;
        endcase
        rv = mfpc_pkg::CFG_W'($urandom_range(2));
        ngrids = 1;
      end else begin
        rv = mfpc_pkg::CFG_W'($urandom_range(6));
        cv = mfpc_pkg::CFG_W'($urandom_range(8));
        ngrids = $urandom_range(4, 1);
      end

      wait_drain();
      if ($urandom_range(1)) begin
        cfg_write(mfpc_pkg::REG_GRID_ROWS, rv);
        cfg_write(mfpc_pkg::REG_GRID_COLS, cv);
      end else begin
        cfg_write(mfpc_pkg::REG_GRID_COLS, cv);
        cfg_write(mfpc_pkg::REG_GRID_ROWS, rv);
      end

      nr = eff_size(rv, MAX_ROWS);
      nc = eff_size(cv, MAX_COLS);
      n  = nr * nc;
      for (int g = 0; g < ngrids; g++) begin
        mode = (r < 12 && $urandom_range(1)) ? FARE_MAX : fare_mode_t'($urandom_range(3));
        for (int k = 0; k < n; k++) send_fare(pick_fare(mode), 1'b0, '0);
      end

      // broken sequence: stop partway; the next write restarts the grid
      if (n > 1 && $urandom_range(7) == 0) begin
        cut = $urandom_range(n - 1, 1);
        for (int k = 0; k < cut; k++) send_fare(pick_fare(FARE_ANY), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    while (min_cost_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
